// File: src/kpi_pkg.sv
`timescale 1ns / 1ps

package kpi_pkg;

   // Table geometry
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Number formats
   localparam int COORD_W = 32;
   localparam int NCOORD  = 6;
   localparam int T_IN_W  = 18;
   localparam int T_W     = 17;
   localparam int FRAC_W  = 16;
   localparam int SCALE_W = T_W + IDX_W;
   localparam int PROD_W  = (COORD_W + 1) + (FRAC_W + 1);

   localparam logic [T_W-1:0]   T_ONE    = T_W'(1 << FRAC_W);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);

   // Item kinds
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_SET_T  = 2'd2;

   // One keyframe: pos x,y,z then look x,y,z
   typedef logic [NCOORD-1:0][COORD_W-1:0] frame_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic scale_en;
      logic fetch_en;
      logic mult_en;
      logic load_out;
   } kpi_cmd_type;

endpackage

// File: src/kpi_ctrl.sv
`timescale 1ns / 1ps

module kpi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kpi_pkg::kpi_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_MULT  = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Sequence one item through the datapath stages
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch_en = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult_en = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Stage commands run in a fixed order after an accepted beat
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.scale_en ##1 cmd.fetch_en ##1 cmd.mult_en)
      else $error("stage commands out of order");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.scale_en, cmd.fetch_en, cmd.mult_en, cmd.load_out}))
      else $error("more than one stage command at once");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid && req_ready)
      else $error("loaded result not presented");

endmodule

// File: src/kpi_datapath.sv
`timescale 1ns / 1ps

module kpi_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kpi_pkg::kpi_cmd_type                 cmd,
   input  logic [1:0]                           req_kind,
   input  kpi_pkg::frame_type                   key_in,
   input  logic signed [kpi_pkg::T_IN_W-1:0]    req_t_value,
   output kpi_pkg::frame_type                   res_frame,
   output logic                                 res_dropped
);

   localparam int IDX_W   = kpi_pkg::IDX_W;
   localparam int CNT_W   = kpi_pkg::CNT_W;
   localparam int T_W     = kpi_pkg::T_W;
   localparam int FRAC_W  = kpi_pkg::FRAC_W;
   localparam int SCALE_W = kpi_pkg::SCALE_W;
   localparam int PROD_W  = kpi_pkg::PROD_W;
   localparam int COORD_W = kpi_pkg::COORD_W;
   localparam int NCOORD  = kpi_pkg::NCOORD;

   // Keyframe memory, one row per keyframe
   kpi_pkg::frame_type key_mem [kpi_pkg::MAX_POINTS];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [T_W-1:0]     param_ff, param_in;
   logic               drop_ff, drop_in;
   logic               full;
   logic               wr_en;

   logic [IDX_W-1:0]   last_ff, last_in;
   logic [SCALE_W-1:0] scaled_ff;
   logic               empty_ff;

   logic [IDX_W:0]     seg;
   logic               at_end;
   logic [IDX_W-1:0]   addr0, addr1;
   logic [FRAC_W-1:0]  frac_ff;
   kpi_pkg::frame_type rd0_ff, rd1_ff;

   logic signed [COORD_W:0]  diff   [NCOORD];
   logic signed [PROD_W-1:0] prod_in [NCOORD];
   logic signed [PROD_W-1:0] prod_ff [NCOORD];
   kpi_pkg::frame_type       base_ff;

   kpi_pkg::frame_type res_in, res_ff;
   logic               res_drop_ff;

   // Apply the accepted beat to count, t and the drop flag
   assign full = (count_ff == kpi_pkg::CNT_FULL);

   always_comb begin
      count_in = count_ff;
      param_in = param_ff;
      drop_in  = 1'b0;
      wr_en    = 1'b0;
      case (req_kind)
         kpi_pkg::KIND_CLEAR: begin
            count_in = '0;
         end
         kpi_pkg::KIND_APPEND: begin
            if (full) begin
               drop_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         kpi_pkg::KIND_SET_T: begin
            if (req_t_value[kpi_pkg::T_IN_W-1]) begin
               param_in = '0;
            end else if (req_t_value[T_W-1:0] > kpi_pkg::T_ONE) begin
               param_in = kpi_pkg::T_ONE;
            end else begin
               param_in = req_t_value[T_W-1:0];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         param_ff <= '0;
      end else if (cmd.accept) begin
         count_ff <= count_in;
         param_ff <= param_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         drop_ff <= drop_in;
      end
   end

   // Write the new keyframe
   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         key_mem[count_ff[IDX_W-1:0]] <= key_in;
      end
   end

   // Scale t by the segment count
   assign last_in = IDX_W'(count_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.scale_en) begin
         last_ff   <= last_in;
         scaled_ff <= SCALE_W'(param_ff) * SCALE_W'(last_in);
         empty_ff  <= (count_ff == '0);
      end
   end

   // Pick the segment; past the last one read the last point twice
   assign seg    = scaled_ff[SCALE_W-1:FRAC_W];
   assign at_end = (seg >= {1'b0, last_ff});
   assign addr0  = at_end ? last_ff : seg[IDX_W-1:0];
   assign addr1  = at_end ? last_ff : seg[IDX_W-1:0] + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.fetch_en) begin
         rd0_ff  <= key_mem[addr0];
         rd1_ff  <= key_mem[addr1];
         frac_ff <= at_end ? '0 : scaled_ff[FRAC_W-1:0];
      end
   end

   // Weight the difference of the two keyframes
   always_comb begin
      for (int c = 0; c < NCOORD; c++) begin
         diff[c]    = $signed({rd1_ff[c][COORD_W-1], rd1_ff[c]})
                    - $signed({rd0_ff[c][COORD_W-1], rd0_ff[c]});
         prod_in[c] = diff[c] * $signed({1'b0, frac_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mult_en) begin
         base_ff <= rd0_ff;
         for (int c = 0; c < NCOORD; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
   end

   // Add the floored step to the start point; empty table gives zeros
   always_comb begin
      for (int c = 0; c < NCOORD; c++) begin
         res_in[c] = empty_ff ? '0
                   : base_ff[c] + COORD_W'(prod_ff[c][FRAC_W+COORD_W-1:FRAC_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         res_ff      <= res_in;
         res_drop_ff <= drop_ff;
      end
   end

   assign res_frame   = res_ff;
   assign res_dropped = res_drop_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kpi_pkg::CNT_FULL)
      else $error("point count above table size");

   a_param_bound: assert property (@(posedge clock) disable iff (reset)
      param_ff <= kpi_pkg::T_ONE)
      else $error("path parameter above one");

endmodule

// File: src/keyframe_path_interpolator_unit.sv
`timescale 1ns / 1ps
// The result beat is offered once the item has passed these steps in order
// (count/t update at the accept edge, then t scaling multiply, registered keyframe read,
// coordinate multiply, add into the output register, which waits until that register is free).
// A new item is taken only after the last one is loaded; the next item is taken while a result waits.
// Reset clears point count and t; keyframe memory is left as is (read only once written).

module keyframe_path_interpolator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [31:0]  req_look_x,
   input  logic signed [31:0]  req_look_y,
   input  logic signed [31:0]  req_look_z,
   input  logic signed [17:0]  req_t_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_out_pos_x,
   output logic signed [31:0]  rsp_out_pos_y,
   output logic signed [31:0]  rsp_out_pos_z,
   output logic signed [31:0]  rsp_out_look_x,
   output logic signed [31:0]  rsp_out_look_y,
   output logic signed [31:0]  rsp_out_look_z,
   output logic                rsp_dropped
);

   kpi_pkg::kpi_cmd_type cmd;
   kpi_pkg::frame_type   key_in;
   kpi_pkg::frame_type   res_frame;

   // Gather the keyframe beat into one row
   assign key_in = {req_look_z, req_look_y, req_look_x, req_pos_z, req_pos_y, req_pos_x};

   kpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   kpi_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_kind    (req_kind),
      .key_in      (key_in),
      .req_t_value (req_t_value),
      .res_frame   (res_frame),
      .res_dropped (rsp_dropped)
   );

   assign rsp_out_pos_x  = res_frame[0];
   assign rsp_out_pos_y  = res_frame[1];
   assign rsp_out_pos_z  = res_frame[2];
   assign rsp_out_look_x = res_frame[3];
   assign rsp_out_look_y = res_frame[4];
   assign rsp_out_look_z = res_frame[5];

endmodule
